>>> hw/rtl/hcl_pkg.sv
`default_nettype none
package hcl_pkg;
	localparam int SLOTS_DEF = 8;
	localparam int GROUP_DEF = 10;
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int MT_W = 8;
	localparam int DIST_W = 9;
	localparam logic [7:0] MATCH_RESET = 8'd20;
	localparam logic [6:0] DARK_RESET = 7'd15;
	localparam logic [1:0] OP_IDENTIFY = 2'd0;
	localparam logic [1:0] OP_LEARN = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [0:0] REG_MATCH = 1'b0;
	localparam logic [0:0] REG_DARK = 1'b1;

	function automatic logic [DIST_W-1:0] hue_dist(input logic [HUE_W-1:0] a,
			input logic [HUE_W-1:0] b);
		logic [HUE_W-1:0] d;
		begin
			d = (a > b) ? (a - b) : (b - a);
			if (d < 9'd180)
				hue_dist = d;
			else if (d > 9'd360)
				hue_dist = 9'd511;
			else
				hue_dist = 9'd360 - d;
		end
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/hcl_sorter.sv
`default_nettype none
// Exchange sort over a register buffer, one compare per cycle; the
// element at index GROUP/2 is reported. Entries hold hue only, since only
// hue is ever read back.
module hcl_sorter #(
	parameter int GROUP = hcl_pkg::GROUP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_en,
	input wire logic [$clog2(GROUP)-1:0] wr_idx,
	input wire logic [hcl_pkg::HUE_W-1:0] wr_hue,
	input wire logic start,
	output logic busy,
	output logic [hcl_pkg::HUE_W-1:0] median
);
	localparam int IW = $clog2(GROUP);
	logic [hcl_pkg::HUE_W-1:0] buf_q [GROUP];
	logic [IW-1:0] a_q, b_q;
	logic busy_q;

	assign busy = busy_q;
	assign median = buf_q[GROUP/2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			a_q <= '0;
			b_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			a_q <= '0;
			b_q <= IW'(1);
		end else if (busy_q) begin
			if (b_q == IW'(GROUP - 1)) begin
				if (a_q == IW'(GROUP - 2))
					busy_q <= 1'b0;
				a_q <= a_q + IW'(1);
				b_q <= a_q + IW'(2);
			end else begin
				b_q <= b_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_idx] <= wr_hue;
		end else if (busy_q && buf_q[b_q] < buf_q[a_q]) begin
			buf_q[a_q] <= buf_q[b_q];
			buf_q[b_q] <= buf_q[a_q];
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/hue_color_learn_and_classify_core.sv
`default_nettype none
// Identify: the table is scanned slot by slot, then the result is registered in ST_OUT.
// Learn sample: a sample that completes a group also waits for the group sort in u_grp, and
// one that completes a run then waits for the median sort in u_med. Clear: empties the table.
// One transaction at a time; the next is accepted in the cycle the result leaves.
// Reset empties the table, zeroes the run counters and loads thresholds.
module hue_color_learn_and_classify_core #(
	parameter int SLOTS = hcl_pkg::SLOTS_DEF,
	parameter int GROUP = hcl_pkg::GROUP_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] op,
	input wire logic [8:0] hue,
	input wire logic [6:0] sat,
	input wire logic [6:0] bright,
	input wire logic [2:0] slot,
	output logic out_valid,
	input wire logic out_stall,
	output logic [3:0] color_code,
	output logic learn_done,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:2] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int IW = $clog2(GROUP);
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_SORT1 = 6'b000100,
		ST_SORT2 = 6'b001000,
		ST_STORE = 6'b010000,
		ST_OUT = 6'b100000
	} state_t;

	state_t state_q;
	logic [7:0] match_q;
	logic [6:0] dark_q;
	logic [8:0] hue_q;
	logic [6:0] sat_q, bright_q;
	logic [2:0] slot_q;
	logic [IW-1:0] samp_q, grp_q;
	logic [SLOTS-1:0] valid_q;
	logic [8:0] tab_q [SLOTS];
	logic [SW-1:0] k_q;
	logic found_q;
	logic [8:0] best_q;
	logic [SW-1:0] best_k_q;
	logic [3:0] code_q;
	logic done_q;
	logic ov_q;

	logic g_wr, g_start, g_busy, m_wr, m_start, m_busy;
	logic [8:0] g_med, m_med, hdist;
	logic acc, wr;

	assign acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (ov_q && out_stall);
	assign out_valid = ov_q;
	assign color_code = code_q;
	assign learn_done = done_q;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == hcl_pkg::REG_DARK) ? {25'd0, dark_q} : {24'd0, match_q};
	assign hdist = hcl_pkg::hue_dist(tab_q[k_q], hue_q);

	assign g_wr = acc && op == hcl_pkg::OP_LEARN;
	assign g_start = acc && op == hcl_pkg::OP_LEARN && samp_q == IW'(GROUP - 1);
	assign m_wr = (state_q == ST_SORT1) && !g_busy;
	assign m_start = m_wr && grp_q == IW'(GROUP - 1);

	hcl_sorter #(.GROUP(GROUP)) u_grp (
		.clk(clk), .arst_n(arst_n), .wr_en(g_wr), .wr_idx(samp_q), .wr_hue(hue),
		.start(g_start), .busy(g_busy), .median(g_med)
	);
	hcl_sorter #(.GROUP(GROUP)) u_med (
		.clk(clk), .arst_n(arst_n), .wr_en(m_wr), .wr_idx(grp_q), .wr_hue(g_med),
		.start(m_start), .busy(m_busy), .median(m_med)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= hcl_pkg::MATCH_RESET;
			dark_q <= hcl_pkg::DARK_RESET;
		end else if (wr) begin
			if (paddr[2] == hcl_pkg::REG_MATCH)
				match_q <= pwdata[7:0];
			else
				dark_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_STORE && !m_busy && {1'b0, slot_q} < 4'(SLOTS))
			tab_q[slot_q[SW-1:0]] <= m_med;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
			valid_q <= '0;
			samp_q <= '0;
			grp_q <= '0;
			k_q <= '0;
			found_q <= 1'b0;
			best_q <= '0;
			best_k_q <= '0;
			code_q <= '0;
			done_q <= 1'b0;
			hue_q <= '0;
			sat_q <= '0;
			bright_q <= '0;
			slot_q <= '0;
		end else begin
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						hue_q <= hue;
						sat_q <= sat;
						bright_q <= bright;
						slot_q <= slot;
						code_q <= '0;
						done_q <= 1'b0;
						k_q <= '0;
						found_q <= 1'b0;
						case (op)
							hcl_pkg::OP_IDENTIFY: state_q <= ST_SCAN;
							hcl_pkg::OP_LEARN: begin
								if (samp_q == IW'(GROUP - 1)) begin
									samp_q <= '0;
									state_q <= ST_SORT1;
								end else begin
									samp_q <= samp_q + IW'(1);
									state_q <= ST_OUT;
								end
							end
							hcl_pkg::OP_CLEAR: begin
								valid_q <= '0;
								state_q <= ST_OUT;
							end
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_SCAN: begin
					if (valid_q[k_q] && (!found_q || hdist < best_q)) begin
						best_q <= hdist;
						best_k_q <= k_q;
						found_q <= 1'b1;
					end
					if (k_q == SW'(SLOTS - 1))
						state_q <= ST_OUT;
					else
						k_q <= k_q + SW'(1);
				end
				ST_SORT1: begin
					if (!g_busy) begin
						if (grp_q == IW'(GROUP - 1)) begin
							grp_q <= '0;
							state_q <= ST_STORE;
						end else begin
							grp_q <= grp_q + IW'(1);
							state_q <= ST_OUT;
						end
					end
				end
				ST_SORT2: state_q <= ST_STORE;
				ST_STORE: begin
					if (!m_busy) begin
						if ({1'b0, slot_q} < 4'(SLOTS))
							valid_q[slot_q[SW-1:0]] <= 1'b1;
						done_q <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					ov_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_SCAN && k_q == SW'(SLOTS - 1)) begin
				if (valid_q[k_q] && (!found_q || hdist < best_q)) begin
					if (hdist <= {1'b0, match_q} && !(sat_q < dark_q && bright_q < dark_q))
						code_q <= 4'({1'b0, k_q} + CW'(1));
				end else if (found_q && best_q <= {1'b0, match_q}
						&& !(sat_q < dark_q && bright_q < dark_q)) begin
					code_q <= 4'({1'b0, best_k_q} + CW'(1));
				end
			end
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("accept while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |=> ov_q) else $error("result lost");
	a_done_code: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q |-> !(learn_done && color_code != 4'd0)) else $error("both fields set");
endmodule
`default_nettype wire

>>> dv/hcl_checker.sv
`timescale 1ns / 1ps
module hcl_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic [1:0] op,
	input wire logic [8:0] hue,
	input wire logic [6:0] sat,
	input wire logic [6:0] bright,
	input wire logic [2:0] slot,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [3:0] color_code,
	input wire logic learn_done,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:2] paddr,
	input wire logic [31:0] pwdata,
	input wire logic pready,
	output int errors,
	output int pending,
	output int runs_done
);
	typedef struct packed {
		logic [3:0] code;
		logic done;
	} verdict_t;
	typedef logic [8:0] hue_set_t [hcl_pkg::GROUP_DEF];

	logic [7:0] match_thr;
	logic [6:0] dark_thr;
	hue_set_t group_hues;
	hue_set_t median_hues;
	int sample_cnt;
	int group_cnt;
	logic [8:0] table_hue [hcl_pkg::SLOTS_DEF];
	logic table_valid [hcl_pkg::SLOTS_DEF];
	verdict_t expected_q [$];

	task automatic report(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	function automatic logic [8:0] middle_hue(input hue_set_t s);
		logic [8:0] t;
		for (int a = 0; a + 1 < hcl_pkg::GROUP_DEF; a++)
			for (int b = a + 1; b < hcl_pkg::GROUP_DEF; b++)
				if (s[b] < s[a]) begin
					t = s[a];
					s[a] = s[b];
					s[b] = t;
				end
		return s[hcl_pkg::GROUP_DEF / 2];
	endfunction

	function automatic int circ_dist(input int a, input int b);
		int d;
		d = (a > b) ? a - b : b - a;
		if (d < 180)
			return d;
		if (d > 360)
			return 511;
		return 360 - d;
	endfunction

	function automatic logic [3:0] nearest_color(input int h, input int s, input int v);
		int best;
		int best_k;
		int d;
		best = 0;
		best_k = -1;
		for (int k = 0; k < hcl_pkg::SLOTS_DEF; k++)
			if (table_valid[k]) begin
				d = circ_dist(table_hue[k], h);
				if (best_k < 0 || d < best) begin
					best = d;
					best_k = k;
				end
			end
		if (best_k < 0 || best > match_thr || (s < dark_thr && v < dark_thr))
			return 4'd0;
		return 4'(best_k + 1);
	endfunction

	assign pending = expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		verdict_t e;
		verdict_t w;
		if (!arst_n) begin
			errors = 0;
			runs_done = 0;
			match_thr = hcl_pkg::MATCH_RESET;
			dark_thr = hcl_pkg::DARK_RESET;
			sample_cnt = 0;
			group_cnt = 0;
			for (int k = 0; k < hcl_pkg::SLOTS_DEF; k++) begin
				table_hue[k] = '0;
				table_valid[k] = 1'b0;
			end
			expected_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr == hcl_pkg::REG_MATCH)
					match_thr = pwdata[7:0];
				else
					dark_thr = pwdata[6:0];
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected transaction", color_code, -1);
				end else begin
					w = expected_q.pop_front();
					if (color_code !== w.code)
						report("color_code", color_code, w.code);
					if (learn_done !== w.done)
						report("learn_done", learn_done, w.done);
					if (w.done)
						runs_done++;
				end
			end
			if (in_valid && !in_stall) begin
				e = '0;
				if (op == hcl_pkg::OP_IDENTIFY) begin
					e.code = nearest_color(hue, sat, bright);
				end else if (op == hcl_pkg::OP_LEARN) begin
					group_hues[sample_cnt] = hue;
					sample_cnt++;
					if (sample_cnt >= hcl_pkg::GROUP_DEF) begin
						sample_cnt = 0;
						median_hues[group_cnt] = middle_hue(group_hues);
						group_cnt++;
						if (group_cnt >= hcl_pkg::GROUP_DEF) begin
							group_cnt = 0;
							if (slot < hcl_pkg::SLOTS_DEF) begin
								table_hue[slot] = middle_hue(median_hues);
								table_valid[slot] = 1'b1;
							end
							e.done = 1'b1;
						end
					end
				end else if (op == hcl_pkg::OP_CLEAR) begin
					for (int k = 0; k < hcl_pkg::SLOTS_DEF; k++)
						table_valid[k] = 1'b0;
				end
				expected_q.push_back(e);
			end
		end
	end
endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
module tb;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [8:0] hue;
	logic [6:0] sat;
	logic [6:0] bright;
	logic [2:0] slot;
	logic out_valid;
	logic out_stall;
	logic [3:0] color_code;
	logic learn_done;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:2] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int errors;
	int pending;
	int runs_done;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_go;
	bit hold_done;
	int items_sent;
	int hue_base [8];

	hue_color_learn_and_classify_core u_top (.*);

	hcl_checker u_chk (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#20ms;
		$display("Run timed out.");
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				out_stall = 1'b1;
				repeat (399) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				out_stall = ($urandom_range(0, 99) < recv_idle_pct);
			end
		end
	end

	task automatic send(input logic [1:0] o, input int h, input int s, input int v,
			input int sl);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		op = o;
		hue = 9'(h);
		sat = 7'(s);
		bright = 7'(v);
		slot = 3'(sl);
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:2] a, input int val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = a;
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic random_identify();
		int h;
		int k;
		k = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			h = $urandom_range(0, 511);
		else
			h = (hue_base[k] + 360 + $urandom_range(0, 60) - 30) % 360;
		if ($urandom_range(0, 4) == 0)
			send(hcl_pkg::OP_IDENTIFY, h, $urandom_range(0, 20), $urandom_range(0, 20),
				$urandom_range(0, 7));
		else
			send(hcl_pkg::OP_IDENTIFY, h, $urandom_range(0, 127), $urandom_range(0, 127),
				$urandom_range(0, 7));
	endtask

	task automatic learn_run();
		int sl;
		int c;
		int h;
		int r;
		sl = $urandom_range(0, 7);
		c = ($urandom_range(0, 9) == 0) ? $urandom_range(340, 511) : $urandom_range(0, 359);
		hue_base[sl] = c % 360;
		for (int n = 0; n < hcl_pkg::GROUP_DEF * hcl_pkg::GROUP_DEF; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				random_identify();
			else if (r == 15)
				send(hcl_pkg::OP_CLEAR, $urandom_range(0, 511), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 7));
			else if (r == 16)
				send(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 7));
			if ($urandom_range(0, 9) == 0)
				h = $urandom_range(0, 511);
			else if (c > 359)
				h = c - $urandom_range(0, 10);
			else
				h = (c + 360 + $urandom_range(0, 30) - 15) % 360;
			send(hcl_pkg::OP_LEARN, h, $urandom_range(0, 127), $urandom_range(0, 127),
				(n == hcl_pkg::GROUP_DEF * hcl_pkg::GROUP_DEF - 1) ? sl : $urandom_range(0, 7));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = hcl_pkg::OP_IDENTIFY;
		hue = '0;
		sat = '0;
		bright = '0;
		slot = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = hcl_pkg::REG_MATCH;
		pwdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_go = 1'b0;
		hold_done = 1'b0;
		items_sent = 0;
		for (int k = 0; k < 8; k++)
			hue_base[k] = 45 * k;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(hcl_pkg::OP_IDENTIFY, 0, 0, 0, 0);
		send(hcl_pkg::OP_IDENTIFY, 511, 127, 127, 7);
		send(OP_UNUSED, 511, 127, 127, 7);
		send(OP_UNUSED, 0, 0, 0, 0);
		send(hcl_pkg::OP_CLEAR, 359, 100, 100, 7);
		send(hcl_pkg::OP_LEARN, 0, 0, 0, 0);
		send(hcl_pkg::OP_LEARN, 511, 127, 127, 7);
		send(hcl_pkg::OP_LEARN, 359, 100, 100, 3);
		send(hcl_pkg::OP_IDENTIFY, 180, 14, 14, 0);
		send(hcl_pkg::OP_CLEAR, 0, 0, 0, 0);
		send(hcl_pkg::OP_LEARN, 180, 50, 50, 4);
		send(hcl_pkg::OP_IDENTIFY, 360, 15, 14, 5);
		settle();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(hcl_pkg::REG_MATCH, 180);
					write_reg(hcl_pkg::REG_DARK, 100);
					send_idle_pct = 24;
					recv_idle_pct = 79;
					hold_go = 1'b1;
				end
				1: begin
					write_reg(hcl_pkg::REG_MATCH, 0);
					write_reg(hcl_pkg::REG_DARK, 0);
					send_idle_pct = 79;
					recv_idle_pct = 24;
				end
				2: begin
					write_reg(hcl_pkg::REG_MATCH, 255);
					write_reg(hcl_pkg::REG_DARK, 127);
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				default: begin
					write_reg(hcl_pkg::REG_MATCH, $urandom_range(5, 40));
					write_reg(hcl_pkg::REG_DARK, $urandom_range(5, 30));
				end
			endcase
			for (int r = 0; r < 3; r++)
				learn_run();
			for (int n = 0; n < 20; n++)
				random_identify();
			settle();
		end

		$display("Sent %0d transactions over four threshold settings and three idle patterns.",
			items_sent);
		$display("Completed %0d learn runs with identify, clear and unused ops interleaved.",
			runs_done);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

>>> filelist.f
hw/rtl/hcl_pkg.sv
hw/rtl/hcl_sorter.sv
hw/rtl/hue_color_learn_and_classify_core.sv
dv/hcl_checker.sv
dv/tb.sv
